/* src/matrix3_inverse_macros.svh */
// Assertion macros used by the matrix inverse top level
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("matrix3_inverse: assertion failed");

// Next-cycle implication, disabled during reset
`define MI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("matrix3_inverse: assertion failed");

`endif

/* src/mi_pkg.sv */
// Types, widths and constants of the 3x3 matrix inverse
package mi_pkg;

	localparam int ELEM_BITS     = 16;
	localparam int FRAC_BITS_DEF = 8;
	localparam int OUT_FRAC      = 16;
	localparam int OUT_BITS      = 32;
	localparam int QBITS         = OUT_BITS;
	localparam int COF_BITS      = 2 * ELEM_BITS + 1;
	localparam int DET_BITS      = 3 * ELEM_BITS + 3;

	// pipeline depth of each part
	localparam int COF_LAT = 2;
	localparam int DET_LAT = 4;
	localparam int DIV_LAT = QBITS + 1;

	localparam logic [OUT_BITS-1:0] SAT_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic [OUT_BITS-1:0] SAT_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

	typedef logic signed [ELEM_BITS-1:0] elem_t;
	typedef logic signed [COF_BITS-1:0]  cof_t;
	typedef logic [DET_BITS-1:0]         dmag_t;

	typedef struct packed {
		logic signed [ELEM_BITS-1:0] a_r1c1;
		logic signed [ELEM_BITS-1:0] a_r1c2;
		logic signed [ELEM_BITS-1:0] a_r1c3;
		logic signed [ELEM_BITS-1:0] a_r2c1;
		logic signed [ELEM_BITS-1:0] a_r2c2;
		logic signed [ELEM_BITS-1:0] a_r2c3;
		logic signed [ELEM_BITS-1:0] a_r3c1;
		logic signed [ELEM_BITS-1:0] a_r3c2;
		logic signed [ELEM_BITS-1:0] a_r3c3;
	} mat_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] inv_r1c1;
		logic signed [OUT_BITS-1:0] inv_r1c2;
		logic signed [OUT_BITS-1:0] inv_r1c3;
		logic signed [OUT_BITS-1:0] inv_r2c1;
		logic signed [OUT_BITS-1:0] inv_r2c2;
		logic signed [OUT_BITS-1:0] inv_r2c3;
		logic signed [OUT_BITS-1:0] inv_r3c1;
		logic signed [OUT_BITS-1:0] inv_r3c2;
		logic signed [OUT_BITS-1:0] inv_r3c3;
		logic                       singular;
	} inv_t;

	// one divider lane as it enters the divider
	typedef struct packed {
		logic                neg;
		logic                sat;
		logic [DET_BITS-1:0] rem;
		logic [QBITS-1:0]    num;
	} lane_t;

endpackage

/* src/matrix3_inverse.sv */
// Top level of the 3x3 fixed-point matrix inverse
//
// Inverts one 3x3 matrix of signed Q8.8 elements per transfer and returns
// the nine elements of the inverse as signed Q16.16, rounded toward zero
// and saturated to 32 bits; a zero determinant raises singular and gives
// all-zero elements.
// Input: the matrix is taken at each rising edge with start high and busy
// low. busy stays low, so a new matrix may be started in every cycle.
// Output: done is high for one cycle with res valid in that same cycle;
// the receiver has no way to hold results off and must take each one.
// Pipeline: the cofactor stages, then the determinant and divider setup
// stages, then the divider, whose 32 stages each resolve one quotient
// bit, and last an output register that holds res.
// Throughput: one matrix per cycle, results in start order.
// Reset clears all valid bits; matrices in flight are dropped.
`include "matrix3_inverse_macros.svh"

module matrix3_inverse #(
	parameter int FRAC_BITS = mi_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  mi_pkg::mat_t mat,
	output logic         done,
	output mi_pkg::inv_t res
);
	import mi_pkg::*;

	localparam int LAT = COF_LAT + DET_LAT + DIV_LAT;

	logic  cof_vld, det_vld;
	cof_t  cof [9];
	elem_t row1 [3];
	lane_t lane [9];
	dmag_t dmag;
	logic  zero;

	// the pipeline never stalls
	assign busy = 1'b0;

	mi_cofactor u_cof (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start && !busy),
		.mat    (mat),
		.vld_o  (cof_vld),
		.cof    (cof),
		.row1   (row1)
	);

	mi_det #(.FRAC_BITS(FRAC_BITS)) u_det (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (cof_vld),
		.cof    (cof),
		.row1   (row1),
		.vld_o  (det_vld),
		.lane   (lane),
		.dmag   (dmag),
		.zero   (zero)
	);

	mi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (det_vld),
		.lane   (lane),
		.dmag   (dmag),
		.zero   (zero),
		.done   (done),
		.res    (res)
	);

	// every transfer in yields one result a fixed latency later
	`MI_ASSERT_NEXT(a_start_done, clk, arst_n, start, ##(LAT-1) done)
	`MI_ASSERT_IMPL(a_done_start, clk, arst_n, done, $past(start, LAT))
	`MI_ASSERT_IMPL(a_singular_zero, clk, arst_n, done && res.singular, res[9*OUT_BITS:1] == '0)

endmodule

/* src/mi_cofactor.sv */
// Cofactor stages: 2x2 products, then signed cofactors
module mi_cofactor (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  mi_pkg::mat_t  mat,
	output logic          vld_o,
	output mi_pkg::cof_t  cof [9],
	output mi_pkg::elem_t row1 [3]
);
	import mi_pkg::*;

	elem_t a [9];
	logic signed [2*ELEM_BITS-1:0] p0_s1 [9];
	logic signed [2*ELEM_BITS-1:0] p1_s1 [9];
	elem_t row1_s1 [3];
	cof_t  cof_s2 [9];
	elem_t row1_s2 [3];
	logic  vld_s1, vld_s2;

	// row-major view of the input
	assign a[0] = mat.a_r1c1;
	assign a[1] = mat.a_r1c2;
	assign a[2] = mat.a_r1c3;
	assign a[3] = mat.a_r2c1;
	assign a[4] = mat.a_r2c2;
	assign a[5] = mat.a_r2c3;
	assign a[6] = mat.a_r3c1;
	assign a[7] = mat.a_r3c2;
	assign a[8] = mat.a_r3c3;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// cyclic row/column choice gives the signed cofactor directly
	for (genvar l = 0; l < 9; l++) begin : g_cof
		localparam int I  = l / 3;
		localparam int J  = l % 3;
		localparam int R0 = (I + 1) % 3;
		localparam int R1 = (I + 2) % 3;
		localparam int K0 = (J + 1) % 3;
		localparam int K1 = (J + 2) % 3;
		always_ff @(posedge clk) begin
			p0_s1[l]  <= a[R0*3+K0] * a[R1*3+K1];
			p1_s1[l]  <= a[R0*3+K1] * a[R1*3+K0];
			cof_s2[l] <= COF_BITS'(p0_s1[l]) - COF_BITS'(p1_s1[l]);
		end
	end

	// first row rides along for the determinant
	for (genvar j = 0; j < 3; j++) begin : g_row
		always_ff @(posedge clk) begin
			row1_s1[j] <= a[j];
			row1_s2[j] <= row1_s1[j];
		end
	end

	assign vld_o = vld_s2;
	assign cof   = cof_s2;
	assign row1  = row1_s2;

endmodule

/* src/mi_det.sv */
// Determinant stages and divider lane setup
module mi_det #(
	parameter int FRAC_BITS = mi_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  mi_pkg::cof_t  cof [9],
	input  mi_pkg::elem_t row1 [3],
	output logic          vld_o,
	output mi_pkg::lane_t lane [9],
	output mi_pkg::dmag_t dmag,
	output logic          zero
);
	import mi_pkg::*;

	localparam int SH = FRAC_BITS + OUT_FRAC;
	localparam int NW = COF_BITS + SH;
	localparam int HB = NW - QBITS;
	localparam int HW = (HB > DET_BITS) ? HB : DET_BITS;

	logic signed [ELEM_BITS+COF_BITS-1:0] dp_s3 [3];
	cof_t  cof_s3 [9];
	cof_t  cof_s4 [9];
	logic signed [DET_BITS-1:0] det_s4;
	logic [COF_BITS-1:0] mag_s5 [9];
	logic  neg_s5 [9];
	dmag_t dmag_s5;
	logic  zero_s5;
	lane_t lane_s6 [9];
	dmag_t dmag_s6;
	logic  zero_s6;
	logic  vld_s3, vld_s4, vld_s5, vld_s6;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s3 <= vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// expansion along row 1: products, then sum
	for (genvar j = 0; j < 3; j++) begin : g_dp
		always_ff @(posedge clk) begin
			dp_s3[j] <= row1[j] * cof[j];
		end
	end

	always_ff @(posedge clk) begin
		det_s4  <= DET_BITS'(dp_s3[0]) + DET_BITS'(dp_s3[1]) + DET_BITS'(dp_s3[2]);
		dmag_s5 <= det_s4[DET_BITS-1] ? dmag_t'(-det_s4) : dmag_t'(det_s4);
		zero_s5 <= (det_s4 == '0);
		dmag_s6 <= dmag_s5;
		zero_s6 <= zero_s5;
	end

	// per lane: transposed cofactor magnitude, sign, then overflow check
	for (genvar l = 0; l < 9; l++) begin : g_lane
		localparam int SRC = (l % 3) * 3 + (l / 3);
		logic [NW-1:0] num;

		assign num = {mag_s5[l], {SH{1'b0}}};

		always_ff @(posedge clk) begin
			cof_s3[l] <= cof[l];
			cof_s4[l] <= cof_s3[l];
			mag_s5[l] <= cof_s4[SRC][COF_BITS-1] ? (COF_BITS)'(-cof_s4[SRC])
				: (COF_BITS)'(cof_s4[SRC]);
			neg_s5[l] <= cof_s4[SRC][COF_BITS-1] ^ det_s4[DET_BITS-1];
			lane_s6[l].neg <= neg_s5[l];
			lane_s6[l].sat <= (HW'(num[NW-1:QBITS]) >= HW'(dmag_s5));
			lane_s6[l].rem <= DET_BITS'(num[NW-1:QBITS]);
			lane_s6[l].num <= num[QBITS-1:0];
		end
	end

	assign vld_o = vld_s6;
	assign lane  = lane_s6;
	assign dmag  = dmag_s6;
	assign zero  = zero_s6;

endmodule

/* src/mi_div.sv */
// Pipelined restoring divider, nine lanes, one quotient bit per stage
module mi_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  mi_pkg::lane_t lane [9],
	input  mi_pkg::dmag_t dmag,
	input  logic          zero,
	output logic          done,
	output mi_pkg::inv_t  res
);
	import mi_pkg::*;

	logic [DET_BITS-1:0] rem_s  [QBITS+1][9];
	logic [QBITS-1:0]    num_s  [QBITS+1][9];
	logic [QBITS-1:0]    quo_s  [QBITS+1][9];
	logic                neg_s  [QBITS+1][9];
	logic                sat_s  [QBITS+1][9];
	dmag_t               dmag_s [QBITS+1];
	logic                zero_s [QBITS+1];
	logic                vld_s  [QBITS+1];
	logic [OUT_BITS-1:0] val [9];
	inv_t                res_q;
	logic                done_q;

	// stage 0 is the incoming lane data
	assign dmag_s[0] = dmag;
	assign zero_s[0] = zero;
	assign vld_s[0]  = vld;
	for (genvar l = 0; l < 9; l++) begin : g_in
		assign rem_s[0][l] = lane[l].rem;
		assign num_s[0][l] = lane[l].num;
		assign quo_s[0][l] = '0;
		assign neg_s[0][l] = lane[l].neg;
		assign sat_s[0][l] = lane[l].sat;
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		// valid travels with the step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dmag_s[k+1] <= dmag_s[k];
			zero_s[k+1] <= zero_s[k];
		end

		// compare and subtract per lane
		for (genvar l = 0; l < 9; l++) begin : g_lane
			logic [DET_BITS:0] trial;
			logic [DET_BITS:0] diff;
			logic              ge;

			assign trial = {rem_s[k][l], num_s[k][l][QBITS-1]};
			assign diff  = trial - {1'b0, dmag_s[k]};
			assign ge    = (trial >= {1'b0, dmag_s[k]});

			always_ff @(posedge clk) begin
				rem_s[k+1][l] <= ge ? diff[DET_BITS-1:0] : trial[DET_BITS-1:0];
				num_s[k+1][l] <= {num_s[k][l][QBITS-2:0], 1'b0};
				quo_s[k+1][l] <= {quo_s[k][l][QBITS-2:0], ge};
				neg_s[k+1][l] <= neg_s[k][l];
				sat_s[k+1][l] <= sat_s[k][l];
			end
		end
	end

	// sign, saturation and the singular case
	for (genvar l = 0; l < 9; l++) begin : g_fin
		logic [QBITS-1:0] q;
		assign q = quo_s[QBITS][l];
		always_comb begin
			if (zero_s[QBITS]) begin
				val[l] = '0;
			end else if (neg_s[QBITS][l]) begin
				val[l] = (sat_s[QBITS][l] || q[QBITS-1]) ? SAT_NEG : OUT_BITS'(-q);
			end else begin
				val[l] = (sat_s[QBITS][l] || q[QBITS-1]) ? SAT_POS : OUT_BITS'(q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		res_q.inv_r1c1 <= val[0];
		res_q.inv_r1c2 <= val[1];
		res_q.inv_r1c3 <= val[2];
		res_q.inv_r2c1 <= val[3];
		res_q.inv_r2c2 <= val[4];
		res_q.inv_r2c3 <= val[5];
		res_q.inv_r3c1 <= val[6];
		res_q.inv_r3c2 <= val[7];
		res_q.inv_r3c3 <= val[8];
		res_q.singular <= zero_s[QBITS];
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
